[rtl/bde_pkg.sv]
package bde_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_WIDTH  = 3'd0,
		REG_BLOCK_SIZE = 3'd1,
		REG_DENSE_MODE = 3'd2,
		REG_DENSE_THR  = 3'd3,
		REG_SPARSE_THR = 3'd4
	} reg_idx_t;

	// Register field widths and reset values
	localparam int ROW_WIDTH_W    = 12;
	localparam int BLOCK_SIZE_W   = 5;
	localparam int THR_W          = 9;
	localparam int ROW_WIDTH_RST  = 640;
	localparam int BLOCK_SIZE_RST = 8;
	localparam logic [THR_W-1:0] DENSE_THR_RST  = 9'd15;
	localparam logic [THR_W-1:0] SPARSE_THR_RST = 9'd30;

	// Pixel stream
	localparam int PIX_W = 8;
	localparam logic [PIX_W-1:0] PIX_ERASED = 8'd0;
	localparam logic [PIX_W-1:0] PIX_KEPT   = 8'd255;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_t;

	// Per-block tracking entry
	localparam int COUNT_W = 9;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               decided;
		logic               erase;
	} cell_t;

	// Pixel attributes sent along with a block update
	typedef struct packed {
		logic first;     // first pixel of the block: start from a clean entry
		logic last_pix;  // final pixel of the block
		logic pix_set;   // pixel is nonzero
		logic bank;      // erase buffer bank being filled
	} cell_req_t;

	// Erase flag write toward the band buffer
	typedef struct packed {
		logic en;
		logic bank;
		logic erase;
	} erase_wr_t;

endpackage

[rtl/bde_ifs.sv]
// Input channel: one command plus pixel per beat
interface bde_in_if import bde_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             command;
	logic [PIX_W-1:0] pixel_in;

	modport source(output valid, command, pixel_in, input ready);
	modport sink(input valid, command, pixel_in, output ready);
endinterface

// Output channel: one output pixel per beat
interface bde_out_if import bde_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             band_last;

	modport source(output valid, pixel_out, band_last, input ready);
	modport sink(input valid, pixel_out, band_last, output ready);
endinterface

[rtl/bde_cell_rmw.sv]
// Per-block count/decision memory with a forwarded read-modify-write loop
module bde_cell_rmw import bde_pkg::*; #(
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	input  cell_req_t        req,
	input  logic             dense,
	input  logic [THR_W-1:0] thr,
	output erase_wr_t        ewr,
	output logic [AW-1:0]    ewr_addr
);

	localparam int SLOTS = 1 << AW;

	cell_t     mem [SLOTS];
	cell_t     rdata_q;
	cell_t     fwd_q;
	logic      fwd_hit_q;
	logic      v_s1;
	cell_req_t req_s1;
	logic [AW-1:0] addr_s1;
	cell_t     cur;
	cell_t     nxt;

	// Stage valid, set for each accepted covered pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			if (rd_en) begin
				fwd_hit_q <= v_s1 && (addr_s1 == rd_addr);
			end
		end
	end

	// Memory port and stage payload
	always_ff @(posedge clk) begin
		if (v_s1) begin
			mem[addr_s1] <= nxt;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			fwd_q   <= nxt;
			req_s1  <= req;
			addr_s1 <= rd_addr;
		end
	end

	// Block update: count set pixels until the deciding zero pixel
	always_comb begin
		if (req_s1.first) begin
			cur = '0;
		end else if (fwd_hit_q) begin
			cur = fwd_q;
		end else begin
			cur = rdata_q;
		end
		nxt = cur;
		if (!cur.decided) begin
			if (req_s1.pix_set) begin
				nxt.count = cur.count + COUNT_W'(1);
			end else if (cur.count > thr) begin
				nxt.decided = 1'b1;
				nxt.erase   = dense;
			end else if (!dense && req_s1.last_pix) begin
				nxt.erase = 1'b1;
			end
		end
	end

	assign ewr.en    = v_s1;
	assign ewr.bank  = req_s1.bank;
	assign ewr.erase = nxt.erase;
	assign ewr_addr  = addr_s1;

endmodule

[rtl/bde_erase_buf.sv]
// Two-bank erase flag buffer: one bank fills while the other drains
module bde_erase_buf import bde_pkg::*; #(
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic          rd_bank,
	input  logic [AW-1:0] rd_addr,
	input  erase_wr_t     ewr,
	input  logic [AW-1:0] ewr_addr,
	output logic          rd_erase
);

	localparam int SLOTS = 1 << AW;

	logic mem [2*SLOTS];
	logic rd_q;
	logic fwd_q;
	logic fwd_hit_q;

	// Same-edge write to the read entry is forwarded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (rd_en) begin
			fwd_hit_q <= ewr.en && (ewr.bank == rd_bank) && (ewr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (ewr.en) begin
			mem[{ewr.bank, ewr_addr}] <= ewr.erase;
		end
		if (rd_en) begin
			rd_q  <= mem[{rd_bank, rd_addr}];
			fwd_q <= ewr.erase;
		end
	end

	assign rd_erase = fwd_hit_q ? fwd_q : rd_q;

endmodule

[rtl/block_density_eraser.sv]
// Block density eraser. Takes a binary image in raster order, one band of
// block_size rows at a time, and decides per square block whether it is
// erased; the band is replayed one band late as 0 (erased) or 255 pixels,
// one output beat per accepted beat while a finished band is pending, with
// drain commands flushing the last band. Throughput is one beat per clock:
// a beat is accepted every cycle unless the output register and the emit
// stage in front of it are both full. Each covered pixel updates its block
// entry in a dual-port read-modify-write memory (read at acceptance, written
// the next cycle, forwarded for back-to-back pixels of the same block), and
// an output beat reads its flag from a two-bank erase buffer that swaps when
// a band completes, then passes the emit stage and the output register.
// Neither memory needs a clearing pass after reset. Writing row_width or
// block_size restarts the stream; write configuration only while idle.
module block_density_eraser import bde_pkg::*; #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_BLOCK = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bde_in_if.sink                feed,
	bde_out_if.source             result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int IW = $clog2(MAX_WIDTH);
	localparam int BW = $clog2(MAX_BLOCK + 1);
	localparam int RW = $clog2(MAX_BLOCK);
	localparam int EW = (CW > ROW_WIDTH_W) ? CW + 1 : ROW_WIDTH_W + 1;
	localparam int W_RST = (ROW_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : ROW_WIDTH_RST;
	localparam int B_RST = (BLOCK_SIZE_RST > MAX_BLOCK) ? MAX_BLOCK : BLOCK_SIZE_RST;

	// Configuration
	logic [CW-1:0]    w_q;
	logic [BW-1:0]    b_q;
	logic             dense_q;
	logic [THR_W-1:0] dthr_q;
	logic [THR_W-1:0] sthr_q;
	logic [EW-1:0]    wr_w;
	logic [BLOCK_SIZE_W-1:0] wr_b;
	logic [CW-1:0]    new_w;
	logic [BW-1:0]    new_b;
	logic             geo_wr;
	logic [THR_W-1:0] thr;

	// Stream positions
	logic [IW-1:0] in_col_q;
	logic [RW-1:0] in_k_q;
	logic [IW-1:0] in_i_q;
	logic [RW-1:0] in_row_q;
	logic [IW-1:0] out_col_q;
	logic [RW-1:0] out_k_q;
	logic [IW-1:0] out_i_q;
	logic [RW-1:0] out_row_q;
	logic          pend_q;
	logic          wbank_q;

	logic in_col_last, in_k_last, in_row_last, in_cov;
	logic out_col_last, out_k_last, out_row_last, out_cov;
	logic acc, take, emit, band_done;

	// Emit stage and output register
	logic             emit_v_s1;
	logic             cov_s1;
	logic             last_s1;
	logic             out_v_q;
	logic [PIX_W-1:0] pixel_q;
	logic             last_q;
	logic             slot_free;
	logic             move;
	logic             erase_rd;

	cell_req_t     cell_req;
	erase_wr_t     ewr;
	logic [IW-1:0] ewr_addr;

	// Clamp geometry writes into range
	always_comb begin
		wr_w = EW'(wr_data[ROW_WIDTH_W-1:0]);
		wr_b = wr_data[BLOCK_SIZE_W-1:0];
		if (wr_w == '0) begin
			new_w = CW'(1);
		end else if (wr_w > EW'(MAX_WIDTH)) begin
			new_w = CW'(MAX_WIDTH);
		end else begin
			new_w = CW'(wr_w);
		end
		if (wr_b == '0) begin
			new_b = BW'(1);
		end else if (wr_b > BLOCK_SIZE_W'(MAX_BLOCK)) begin
			new_b = BW'(MAX_BLOCK);
		end else begin
			new_b = BW'(wr_b);
		end
	end

	assign geo_wr = wr_en && ((reg_idx_t'(wr_index) == REG_ROW_WIDTH) ||
		(reg_idx_t'(wr_index) == REG_BLOCK_SIZE));

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= CW'(W_RST);
			b_q     <= BW'(B_RST);
			dense_q <= 1'b1;
			dthr_q  <= DENSE_THR_RST;
			sthr_q  <= SPARSE_THR_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_ROW_WIDTH:  w_q     <= new_w;
				REG_BLOCK_SIZE: b_q     <= new_b;
				REG_DENSE_MODE: dense_q <= wr_data[0];
				REG_DENSE_THR:  dthr_q  <= wr_data[THR_W-1:0];
				REG_SPARSE_THR: sthr_q  <= wr_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign thr = dense_q ? dthr_q : sthr_q;

	// Beat classification
	assign acc       = feed.valid && feed.ready;
	assign take      = acc && (cmd_t'(feed.command) == CMD_PIXEL);
	assign emit      = acc && pend_q;
	assign band_done = take && in_col_last && in_row_last;

	// Position decode: a column is covered when its whole block fits the row
	assign in_col_last  = (EW'(in_col_q) + EW'(1)) >= EW'(w_q);
	assign in_k_last    = (BW'(in_k_q) + BW'(1)) >= b_q;
	assign in_row_last  = (BW'(in_row_q) + BW'(1)) >= b_q;
	assign in_cov       = (EW'(in_col_q) - EW'(in_k_q) + EW'(b_q)) <= EW'(w_q);
	assign out_col_last = (EW'(out_col_q) + EW'(1)) >= EW'(w_q);
	assign out_k_last   = (BW'(out_k_q) + BW'(1)) >= b_q;
	assign out_row_last = (BW'(out_row_q) + BW'(1)) >= b_q;
	assign out_cov      = (EW'(out_col_q) - EW'(out_k_q) + EW'(b_q)) <= EW'(w_q);

	// Input and output position counters; band completion wins over emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_k_q    <= '0;
			in_i_q    <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_k_q   <= '0;
			out_i_q   <= '0;
			out_row_q <= '0;
			pend_q    <= 1'b0;
			wbank_q   <= 1'b0;
		end else if (geo_wr) begin
			in_col_q  <= '0;
			in_k_q    <= '0;
			in_i_q    <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_k_q   <= '0;
			out_i_q   <= '0;
			out_row_q <= '0;
			pend_q    <= 1'b0;
		end else begin
			if (emit) begin
				if (out_col_last) begin
					out_col_q <= '0;
					out_k_q   <= '0;
					out_i_q   <= '0;
					if (out_row_last) begin
						out_row_q <= '0;
						pend_q    <= 1'b0;
					end else begin
						out_row_q <= out_row_q + RW'(1);
					end
				end else begin
					out_col_q <= out_col_q + IW'(1);
					if (out_k_last) begin
						out_k_q <= '0;
						out_i_q <= out_i_q + IW'(1);
					end else begin
						out_k_q <= out_k_q + RW'(1);
					end
				end
			end
			if (take) begin
				if (in_col_last) begin
					in_col_q <= '0;
					in_k_q   <= '0;
					in_i_q   <= '0;
					if (in_row_last) begin
						in_row_q <= '0;
					end else begin
						in_row_q <= in_row_q + RW'(1);
					end
				end else begin
					in_col_q <= in_col_q + IW'(1);
					if (in_k_last) begin
						in_k_q <= '0;
						in_i_q <= in_i_q + IW'(1);
					end else begin
						in_k_q <= in_k_q + RW'(1);
					end
				end
			end
			if (band_done) begin
				out_col_q <= '0;
				out_k_q   <= '0;
				out_i_q   <= '0;
				out_row_q <= '0;
				pend_q    <= 1'b1;
				wbank_q   <= ~wbank_q;
			end
		end
	end

	// Block update path
	assign cell_req.first    = (in_row_q == '0) && (in_k_q == '0);
	assign cell_req.last_pix = in_row_last && in_k_last;
	assign cell_req.pix_set  = (feed.pixel_in != '0);
	assign cell_req.bank     = wbank_q;

	bde_cell_rmw #(
		.DEPTH(MAX_WIDTH)
	) u_cell (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (take && in_cov),
		.rd_addr  (in_i_q),
		.req      (cell_req),
		.dense    (dense_q),
		.thr      (thr),
		.ewr      (ewr),
		.ewr_addr (ewr_addr)
	);

	bde_erase_buf #(
		.DEPTH(MAX_WIDTH)
	) u_ebuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (emit),
		.rd_bank  (~wbank_q),
		.rd_addr  (out_i_q),
		.ewr      (ewr),
		.ewr_addr (ewr_addr),
		.rd_erase (erase_rd)
	);

	// Emit stage feeding the output register
	assign slot_free  = !out_v_q || result.ready;
	assign move       = emit_v_s1 && slot_free;
	assign feed.ready = !emit_v_s1 || slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_v_s1 <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (acc) begin
				emit_v_s1 <= emit;
			end else if (move) begin
				emit_v_s1 <= 1'b0;
			end
			if (move) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cov_s1  <= out_cov;
			last_s1 <= out_row_last && out_col_last;
		end
		if (move) begin
			pixel_q <= (cov_s1 && erase_rd) ? PIX_ERASED : PIX_KEPT;
			last_q  <= last_s1;
		end
	end

	assign result.valid     = out_v_q;
	assign result.pixel_out = pixel_q;
	assign result.band_last = last_q;

`ifndef ASSERT_OFF
	// A beat with no pending band releases nothing
	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !pend_q |=> !emit_v_s1)
		else $error("emit stage loaded without a pending band");

	// Output position stays inside the band while one is pending
	a_out_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (BW'(out_row_q) < b_q))
		else $error("output row beyond band");

	// Input stalls only when both emit slots are full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!feed.ready |-> emit_v_s1 && out_v_q && !result.ready)
		else $error("input stalled without a full output path");

	// Band completion swaps banks and restarts output at band start
	a_band_swap: assert property (@(posedge clk) disable iff (!arst_n)
		band_done && !geo_wr |=> pend_q && (out_col_q == '0) && (out_row_q == '0)
			&& (wbank_q != $past(wbank_q)))
		else $error("band completion did not swap erase banks");
`endif

endmodule

[sim/block_density_eraser_tb.sv]
`timescale 1ns / 100ps

module block_density_eraser_tb;
	import bde_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int MAX_W        = 2048;
	localparam int MAX_B        = 16;
	localparam int SETTLE       = 6;     // output trails its releasing beat through the emit stage and output register
	localparam int END_WAIT     = 20;
	localparam int QUIET_LIMIT  = 3000;
	localparam int RX_HOLD      = 300;
	localparam int TOTAL_ITEMS  = 1150;  // queued input beats before random settings stop
	localparam int MAX_REPORTS  = 20;

	// Index past the register list; writes to it must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	// Hand-picked bands for the 3x2 geometry: one 2x2 block plus a trailing column
	localparam logic [6*PIX_W-1:0] BAND_A = {8'h08, 8'h04, 8'h02, 8'h01, 8'hFF, 8'h00};
	localparam logic [6*PIX_W-1:0] BAND_B = {8'h7F, 8'h00, 8'h80, 8'h40, 8'h00, 8'h10};

	typedef struct {
		cmd_t             cmd;
		logic [PIX_W-1:0] pix;
	} feed_item_t;

	typedef struct {
		logic [PIX_W-1:0] pix;
		logic             last;
	} out_pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	bde_in_if  feed ();
	bde_out_if result ();

	block_density_eraser #(
		.MAX_WIDTH(MAX_W),
		.MAX_BLOCK(MAX_B)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.feed    (feed),
		.result  (result),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Stimulus and expected output pixels
	feed_item_t feed_queue[$];
	out_pixel_t expected_pixels[$];

	// Eraser state as the block should hold it
	logic [ROW_WIDTH_W-1:0]  cfg_width      = ROW_WIDTH_W'(ROW_WIDTH_RST);
	logic [BLOCK_SIZE_W-1:0] cfg_block      = BLOCK_SIZE_W'(BLOCK_SIZE_RST);
	bit                      cfg_dense      = 1'b1;
	logic [THR_W-1:0]        cfg_dense_thr  = DENSE_THR_RST;
	logic [THR_W-1:0]        cfg_sparse_thr = SPARSE_THR_RST;

	bit [COUNT_W-1:0] blk_count   [MAX_W];
	bit               blk_decided [MAX_W];
	bit               blk_erase   [MAX_W];
	bit               done_erase  [MAX_W];
	int unsigned      in_row, in_col, out_row, out_col;
	bit               band_ready;

	// Bookkeeping
	int unsigned errors, phases, items_queued;
	int unsigned pixels_in, drains_in, outputs_checked, erased_seen;
	int unsigned quiet_cycles;
	int unsigned tx_gap, tx_burst, rx_stall, rx_burst, rx_roll;
	bit          stall_armed, stall_done;
	feed_item_t  next_item;

	// Effective geometry after clamping out-of-range register values
	function automatic void geometry(output int unsigned w, output int unsigned b);
		w = (cfg_width == 0) ? 1 : (cfg_width > MAX_W) ? MAX_W : cfg_width;
		b = (cfg_block == 0) ? 1 : (cfg_block > MAX_B) ? MAX_B : cfg_block;
	endfunction

	// Idle length: mostly short, now and then long
	function automatic int unsigned gap_length();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// One accepted input beat: release a pending pixel, then take the new one
	function automatic void erase_beat(input cmd_t cmd, input logic [PIX_W-1:0] pix);
		int unsigned w, b, covered, blk, k, thr;
		out_pixel_t  o;
		geometry(w, b);
		covered = (w / b) * b;

		// replay of the finished band, one pixel per beat
		if (band_ready) begin
			o.pix  = (out_col < covered && done_erase[out_col / b]) ? PIX_ERASED : PIX_KEPT;
			o.last = (out_row + 1 >= b) && (out_col + 1 >= w);
			expected_pixels.push_back(o);
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
				if (out_row >= b) begin
					out_row    = 0;
					band_ready = 1'b0;
				end
			end
		end
		if (cmd != CMD_PIXEL)
			return;

		// block decision; trailing columns are never examined
		thr = cfg_dense ? cfg_dense_thr : cfg_sparse_thr;
		if (in_col < covered) begin
			blk = in_col / b;
			k   = in_col % b;
			if (in_row == 0 && k == 0) begin
				blk_count[blk]   = '0;
				blk_decided[blk] = 1'b0;
				blk_erase[blk]   = 1'b0;
			end
			if (!blk_decided[blk]) begin
				if (pix != 0)
					blk_count[blk] = blk_count[blk] + 1'b1;
				else if (blk_count[blk] > thr) begin
					blk_decided[blk] = 1'b1;
					blk_erase[blk]   = cfg_dense;
				end else if (!cfg_dense && in_row + 1 == b && k + 1 == b)
					blk_erase[blk] = 1'b1;
			end
		end

		// band complete: it becomes the pending band
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
			if (in_row >= b) begin
				in_row     = 0;
				done_erase = blk_erase;
				band_ready = 1'b1;
				out_row    = 0;
				out_col    = 0;
			end
		end
	endfunction

	// Register write, mirrored in the predictor; only called while idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		case (idx)
			REG_ROW_WIDTH, REG_BLOCK_SIZE: begin
				if (idx == REG_ROW_WIDTH)
					cfg_width = data[ROW_WIDTH_W-1:0];
				else
					cfg_block = data[BLOCK_SIZE_W-1:0];
				// geometry change restarts the stream
				in_row     = 0;
				in_col     = 0;
				out_row    = 0;
				out_col    = 0;
				band_ready = 1'b0;
			end
			REG_DENSE_MODE: cfg_dense      = data[0];
			REG_DENSE_THR:  cfg_dense_thr  = data[THR_W-1:0];
			REG_SPARSE_THR: cfg_sparse_thr = data[THR_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic push_item(input cmd_t cmd, input logic [PIX_W-1:0] pix);
		feed_item_t it;
		it.cmd = cmd;
		it.pix = pix;
		feed_queue.push_back(it);
		items_queued++;
	endtask

	// Wait for every beat to be taken and every output to arrive
	task automatic wait_idle();
		while (feed_queue.size() != 0 || feed.valid || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Pixels with a random density, drain commands sprinkled in
	task automatic queue_pixels(input int unsigned n);
		int unsigned density, drain_pct;
		density   = $urandom_range(0, 100);
		drain_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
		repeat (n) begin
			if ($urandom_range(0, 99) < drain_pct)
				push_item(CMD_DRAIN, PIX_W'($urandom));
			if ($urandom_range(0, 99) < density)
				push_item(CMD_PIXEL, PIX_W'($urandom_range(1, 255)));
			else
				push_item(CMD_PIXEL, PIX_W'(0));
		end
	endtask

	// Flush whatever is left of the pending band with drain commands
	task automatic drain_band();
		int unsigned w, b, left;
		while (feed_queue.size() != 0 || feed.valid)
			@(negedge clk);
		geometry(w, b);
		left = band_ready ? (b - out_row) * w - out_col : 0;
		repeat (left) push_item(CMD_DRAIN, PIX_W'($urandom));
	endtask

	// One setting: all registers written (random bits above each field), then bands
	task automatic run_phase(input int unsigned w, input int unsigned b, input bit dense,
			input int unsigned dthr, input int unsigned sthr, input int unsigned bands,
			input bit partial, input bit hold);
		int unsigned ew, eb, n;
		wait_idle();
		write_reg(REG_ROW_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_BLOCK_SIZE, (CFG_DATA_W'($urandom) << BLOCK_SIZE_W) | CFG_DATA_W'(b));
		write_reg(REG_DENSE_MODE, (CFG_DATA_W'($urandom) << 1) | CFG_DATA_W'(dense));
		write_reg(REG_DENSE_THR, (CFG_DATA_W'($urandom) << THR_W) | CFG_DATA_W'(dthr));
		write_reg(REG_SPARSE_THR, (CFG_DATA_W'($urandom) << THR_W) | CFG_DATA_W'(sthr));
		geometry(ew, eb);
		n = ew * eb;
		if (hold)
			stall_armed = 1'b1;
		repeat (bands) queue_pixels(n);
		if (partial && n > 1)
			queue_pixels($urandom_range(1, n - 1));
		drain_band();
		phases++;
	endtask

	// Input driver: one beat per queue entry, random gaps and gap-free bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed.valid    <= 1'b0;
			feed.command  <= CMD_PIXEL;
			feed.pixel_in <= '0;
			tx_gap        <= 0;
			tx_burst      <= 0;
		end else begin
			if (feed.valid && feed.ready) begin
				erase_beat(cmd_t'(feed.command), feed.pixel_in);
				if (feed.command == CMD_PIXEL)
					pixels_in++;
				else
					drains_in++;
			end
			if (!feed.valid || feed.ready) begin
				if (tx_gap > 0) begin
					feed.valid <= 1'b0;
					tx_gap     <= tx_gap - 1;
				end else if (feed_queue.size() > 0) begin
					next_item      = feed_queue.pop_front();
					feed.valid    <= 1'b1;
					feed.command  <= next_item.cmd;
					feed.pixel_in <= next_item.pix;
					if (tx_burst > 0) begin
						tx_burst <= tx_burst - 1;
						tx_gap   <= 0;
					end else if ($urandom_range(0, 49) == 0) begin
						tx_burst <= $urandom_range(30, 80);
						tx_gap   <= 0;
					end else
						tx_gap <= gap_length();
				end else
					feed.valid <= 1'b0;
			end
		end
	end

	// Output ready: random stalls, bursts, and one long hold once armed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			rx_stall     <= 0;
			rx_burst     <= 0;
		end else if (stall_armed && !stall_done && result.valid && result.ready) begin
			result.ready <= 1'b0;
			rx_stall     <= RX_HOLD;
			stall_done   <= 1'b1;
		end else if (rx_stall > 0) begin
			result.ready <= 1'b0;
			rx_stall     <= rx_stall - 1;
		end else if (rx_burst > 0) begin
			result.ready <= 1'b1;
			rx_burst     <= rx_burst - 1;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 3) begin
				result.ready <= 1'b1;
				rx_burst     <= $urandom_range(30, 80);
			end else if (rx_roll < 30) begin
				result.ready <= 1'b0;
				rx_stall     <= gap_length();
			end else
				result.ready <= 1'b1;
		end
	end

	// Output check against the oldest expected pixel
	always @(posedge clk) begin
		out_pixel_t want;
		if (arst_n && result.valid && result.ready) begin
			if (expected_pixels.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: output beat with none expected: pixel_out %0d band_last %0d",
						$time, result.pixel_out, result.band_last);
			end else begin
				want = expected_pixels.pop_front();
				if (result.pixel_out !== want.pix) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: pixel_out expected %0d, got %0d",
							$time, want.pix, result.pixel_out);
				end
				if (result.band_last !== want.last) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: band_last expected %0d, got %0d",
							$time, want.last, result.band_last);
				end
				outputs_checked++;
				if (want.pix == PIX_ERASED)
					erased_seen++;
			end
		end
	end

	// Watchdog on cycles without any beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((feed.valid && feed.ready) || (result.valid && result.ready))
				quiet_cycles <= 0;
			else if (quiet_cycles == QUIET_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d outputs still expected",
					$time, QUIET_LIMIT, expected_pixels.size());
				$display("Some tests failed");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned w, b, dthr, sthr, bands;
		feed.valid    = 1'b0;
		feed.command  = CMD_PIXEL;
		feed.pixel_in = '0;
		result.ready  = 1'b0;
		wr_en         = 1'b0;
		wr_index      = REG_ROW_WIDTH;
		wr_data       = '0;
		arst_n        = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: drain with nothing pending, then 3x2 geometry with extreme values
		push_item(CMD_DRAIN, 8'hA5);
		wait_idle();
		write_reg(REG_ROW_WIDTH, CFG_DATA_W'(3));
		write_reg(REG_BLOCK_SIZE, CFG_DATA_W'(2));
		write_reg(REG_DENSE_MODE, CFG_DATA_W'(1));
		write_reg(REG_DENSE_THR, CFG_DATA_W'(0));
		write_reg(REG_SPARSE_THR, CFG_DATA_W'(9'h1FF));
		write_reg(REG_NONE, '1);
		for (int i = 0; i < 6; i++)
			push_item(CMD_PIXEL, BAND_A[i*PIX_W +: PIX_W]);
		push_item(CMD_DRAIN, 8'h5A);
		for (int i = 0; i < 6; i++)
			push_item(CMD_PIXEL, BAND_B[i*PIX_W +: PIX_W]);
		drain_band();
		// partial band with nothing pending, then an idle drain
		push_item(CMD_PIXEL, 8'hFF);
		push_item(CMD_PIXEL, 8'h00);
		push_item(CMD_DRAIN, 8'h00);
		phases++;

		// Geometry and threshold extremes
		run_phase(0, 0, 1'b1, 0, 0, 6, 1'b1, 1'b0);        // both clamp up to 1
		run_phase(1, 1, 1'b0, 0, 0, 8, 1'b0, 1'b0);
		run_phase(3, 5, 1'b0, 3, 0, 2, 1'b1, 1'b0);        // narrower than a block
		run_phase(20, 31, 1'b1, 256, 20, 1, 1'b0, 1'b1);   // block clamps to 16, long hold
		run_phase(8, 8, 1'b0, 10, 256, 1, 1'b1, 1'b0);

		// Random settings, mostly small blocks, until the beat budget is used
		while (items_queued < TOTAL_ITEMS) begin
			if ($urandom_range(0, 9) < 8) begin
				b     = $urandom_range(1, 6);
				bands = $urandom_range(1, 3);
				w     = b * $urandom_range(1, 3) + $urandom_range(0, b - 1);
			end else begin
				b     = $urandom_range(7, 10);
				bands = 1;
				w     = b + $urandom_range(0, 3);
			end
			if ($urandom_range(0, 9) == 0)
				w = $urandom_range(1, b);
			dthr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : $urandom_range(0, b * b);
			sthr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : $urandom_range(0, b * b);
			run_phase(w, b, $urandom_range(0, 1), dthr, sthr, bands, $urandom_range(0, 1), 1'b0);
		end

		wait_idle();
		repeat (END_WAIT) @(negedge clk);
		$display("Covered %0d settings: %0d pixel beats and %0d drain beats in,",
			phases, pixels_in, drains_in);
		$display("%0d output beats checked, %0d of them erased, %0d mismatches.",
			outputs_checked, erased_seen, errors);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
